@@ rtl/ctt_pkg.sv @@
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the configuration text tokenizer
// byte codes, lexer modes, token kinds and the per-byte result entry
// ----------------------------------------------------------------------------
package ctt_pkg;

  typedef enum logic [2:0] {
    MODE_ROOT     = 3'd0,
    MODE_NAME     = 3'd1,
    MODE_QUOTE    = 3'd2,
    MODE_AFTER_EQ = 3'd3,
    MODE_SKIP     = 3'd4,
    MODE_VALUE    = 3'd5,
    MODE_COMMENT  = 3'd6
  } mode_t;

  localparam logic [2:0] TK_NAME   = 3'd0;
  localparam logic [2:0] TK_DOTTED = 3'd1;
  localparam logic [2:0] TK_EQUAL  = 3'd2;
  localparam logic [2:0] TK_OPEN   = 3'd3;
  localparam logic [2:0] TK_CLOSE  = 3'd4;
  localparam logic [2:0] TK_VALUE  = 3'd5;

  localparam logic KIND_LEXEME   = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef struct packed {
    logic       item_kind;
    logic [2:0] token_kind;
    logic [7:0] lexeme_byte;
  } res_t;

  // one queue entry: the results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } qent_t;

endpackage

@@ rtl/config_text_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// config_text_tokenizer_core: configuration text tokenizer
// one text byte per transfer in, name/value lexeme bytes and token
// completions out
// ----------------------------------------------------------------------------
// Takes one text byte per cycle whenever the result queue has room; each byte
// is classified combinationally and its one or two results, if any, are queued
// as one entry. Results leave one per cycle while out_ready is high, so a byte
// that closes a name and opens another token takes two output transfers. The
// results of an accepted byte are registered in the queue before they are
// presented; the input side stalls only when QUEUE_DEPTH entries are waiting.
module config_text_tokenizer_core
  import ctt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_item_kind,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_lexeme_byte,
  output logic       out_last_result
);

  qent_t q_data, q_head;
  logic  q_push, q_full, q_pop, q_empty;
  logic  phase;
  mode_t mode;

  ctt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data),
    .mode           (mode)
  );

  ctt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ctt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .phase           (phase),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_token_kind  (out_token_kind),
    .out_lexeme_byte (out_lexeme_byte),
    .out_last_result (out_last_result)
  );

  // end of text returns the lexer to root
  a_end_root: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_end_of_text) |=> (mode == MODE_ROOT))
    else $error("lexer not at root after end of text");

  // a last result transfer restarts the sequencer on the next entry
  a_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_result) |=> !phase)
    else $error("sequencer phase not cleared");

  // the second result of an entry is always the last one
  a_phase_last: assert property (@(posedge clk) disable iff (!rst_n)
    (phase && out_valid) |-> out_last_result)
    else $error("second result not marked last");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

@@ rtl/ctt_front.sv @@
// ----------------------------------------------------------------------------
// ctt_front: byte classifier
// holds the lexer mode and builds the results of each accepted byte
// ----------------------------------------------------------------------------
module ctt_front
  import ctt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  input  logic       q_full,
  output logic       q_push,
  output qent_t      q_data,
  output mode_t      mode
);

  mode_t mode_r, mode_nxt;
  logic  crv_r, crv_nxt;
  logic  dot_r, dot_nxt;
  logic  [1:0] n_res;
  logic  accept;
  logic  [7:0] b;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic res_t mk(input logic k, input logic [2:0] t, input logic [7:0] d);
    res_t r;
    r.item_kind   = k;
    r.token_kind  = t;
    r.lexeme_byte = d;
    return r;
  endfunction

  assign b        = in_text_byte;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign mode     = mode_r;

  // next state
  always_comb begin
    mode_nxt = mode_r;
    crv_nxt  = crv_r;
    dot_nxt  = dot_r;
    if (in_end_of_text) begin
      mode_nxt = MODE_ROOT;
      crv_nxt  = 1'b0;
      dot_nxt  = 1'b0;
    end else begin
      case (mode_r)
        MODE_NAME: begin
          if (is_letter(b) || is_num(b)) begin
            mode_nxt = MODE_NAME;
          end else if (b == CH_DOT) begin
            dot_nxt = 1'b1;
          end else if (b == CH_QUOTE) begin
            mode_nxt = MODE_QUOTE;
          end else begin
            mode_nxt = MODE_ROOT;
            dot_nxt  = 1'b0;
            if (is_letter(b)) begin
              mode_nxt = MODE_NAME;
            end else if (b == CH_HASH) begin
              crv_nxt  = 1'b0;
              mode_nxt = MODE_COMMENT;
            end else if (b == CH_EQUAL) begin
              mode_nxt = MODE_AFTER_EQ;
            end
          end
        end
        MODE_QUOTE: begin
          if (b == CH_QUOTE) mode_nxt = MODE_NAME;
        end
        MODE_AFTER_EQ: begin
          if (b == CH_HASH) begin
            crv_nxt  = 1'b1;
            mode_nxt = MODE_COMMENT;
          end else if ((b == CH_SPACE) || (b == CH_LF)) begin
            mode_nxt = MODE_SKIP;
          end else begin
            mode_nxt = MODE_VALUE;
          end
        end
        MODE_SKIP: begin
          if ((b != CH_SPACE) && (b != CH_LF)) mode_nxt = MODE_VALUE;
        end
        MODE_VALUE: begin
          if ((b == CH_LF) || (b == CH_CR)) mode_nxt = MODE_ROOT;
        end
        MODE_COMMENT: begin
          if (b == CH_LF) mode_nxt = crv_r ? MODE_SKIP : MODE_ROOT;
        end
        default: begin
          mode_nxt = MODE_ROOT;
          if (is_letter(b)) begin
            mode_nxt = MODE_NAME;
            dot_nxt  = 1'b0;
          end else if (b == CH_HASH) begin
            crv_nxt  = 1'b0;
            mode_nxt = MODE_COMMENT;
          end else if (b == CH_EQUAL) begin
            mode_nxt = MODE_AFTER_EQ;
          end
        end
      endcase
    end
  end

  // results of this byte
  always_comb begin
    logic [2:0] tk;
    logic       rv;
    res_t       rr;
    tk = dot_r ? TK_DOTTED : TK_NAME;
    rv = 1'b0;
    rr = mk(KIND_LEXEME, TK_NAME, b);
    // what a byte gives at root
    if (is_letter(b)) begin
      rv = 1'b1;
      rr = mk(KIND_LEXEME, TK_NAME, b);
    end else if (b == CH_EQUAL) begin
      rv = 1'b1;
      rr = mk(KIND_COMPLETE, TK_EQUAL, 8'h00);
    end else if (b == CH_LBRACK) begin
      rv = 1'b1;
      rr = mk(KIND_COMPLETE, TK_OPEN, 8'h00);
    end else if (b == CH_RBRACK) begin
      rv = 1'b1;
      rr = mk(KIND_COMPLETE, TK_CLOSE, 8'h00);
    end
    n_res     = 2'd0;
    q_data.r0 = mk(KIND_LEXEME, tk, b);
    q_data.r1 = rr;
    if (in_end_of_text) begin
      if ((mode_r == MODE_NAME) || (mode_r == MODE_QUOTE)) begin
        n_res     = 2'd1;
        q_data.r0 = mk(KIND_COMPLETE, tk, 8'h00);
      end else if (mode_r == MODE_VALUE) begin
        n_res     = 2'd1;
        q_data.r0 = mk(KIND_COMPLETE, TK_VALUE, 8'h00);
      end
    end else begin
      case (mode_r)
        MODE_NAME: begin
          n_res = 2'd1;
          if (is_letter(b) || is_num(b) || (b == CH_QUOTE)) begin
            q_data.r0 = mk(KIND_LEXEME, tk, b);
          end else if (b == CH_DOT) begin
            q_data.r0 = mk(KIND_LEXEME, TK_DOTTED, b);
          end else begin
            q_data.r0 = mk(KIND_COMPLETE, tk, 8'h00);
            n_res     = rv ? 2'd2 : 2'd1;
          end
        end
        MODE_QUOTE: begin
          n_res     = 2'd1;
          q_data.r0 = mk(KIND_LEXEME, tk, b);
        end
        MODE_AFTER_EQ: begin
          if ((b != CH_HASH) && (b != CH_SPACE) && (b != CH_LF)) begin
            n_res     = 2'd1;
            q_data.r0 = mk(KIND_LEXEME, TK_VALUE, b);
          end
        end
        MODE_SKIP: begin
          if ((b != CH_SPACE) && (b != CH_LF)) begin
            n_res     = 2'd1;
            q_data.r0 = mk(KIND_LEXEME, TK_VALUE, b);
          end
        end
        MODE_VALUE: begin
          n_res = 2'd1;
          if ((b == CH_LF) || (b == CH_CR)) begin
            q_data.r0 = mk(KIND_COMPLETE, TK_VALUE, 8'h00);
          end else begin
            q_data.r0 = mk(KIND_LEXEME, TK_VALUE, b);
          end
        end
        MODE_COMMENT: begin
          n_res = 2'd0;
        end
        default: begin
          n_res     = rv ? 2'd1 : 2'd0;
          q_data.r0 = rr;
        end
      endcase
    end
    q_data.two = (n_res == 2'd2);
  end

  assign q_push = accept && (n_res != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ROOT;
      crv_r  <= 1'b0;
      dot_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      crv_r  <= crv_nxt;
      dot_r  <= dot_nxt;
    end
  end

endmodule

@@ rtl/ctt_queue.sv @@
// ----------------------------------------------------------------------------
// ctt_queue: result entry queue
// small first-in first-out store between classifier and result sequencer
// ----------------------------------------------------------------------------
module ctt_queue
  import ctt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t head,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  qent_t         mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULLC);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == LAST) ? '0 : wr_r + 1'b1;
      if (do_pop) rd_r <= (rd_r == LAST) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ rtl/ctt_back.sv @@
// ----------------------------------------------------------------------------
// ctt_back: result sequencer
// presents the one or two results of each queued entry, one per transfer
// ----------------------------------------------------------------------------
module ctt_back
  import ctt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qent_t      head,
  input  logic       empty,
  output logic       pop,
  output logic       phase,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_item_kind,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_lexeme_byte,
  output logic       out_last_result
);

  logic phase_r, phase_nxt;
  logic xfer;
  res_t cur;

  assign out_valid       = !empty;
  assign cur             = phase_r ? head.r1 : head.r0;
  assign out_item_kind   = cur.item_kind;
  assign out_token_kind  = cur.token_kind;
  assign out_lexeme_byte = cur.lexeme_byte;
  assign out_last_result = phase_r || !head.two;
  assign xfer            = out_valid && out_ready;
  assign pop             = xfer && out_last_result;
  assign phase           = phase_r;

  always_comb begin
    phase_nxt = phase_r;
    if (xfer) phase_nxt = !out_last_result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ verif/config_text_tokenizer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_core_tb: self-checking bench for the tokenizer core
// drives directed and generated configuration text through the byte channel,
// predicts every lexeme byte and token completion, and checks the result
// channel in order under idle, stall and long back-pressure phases
// ----------------------------------------------------------------------------
module config_text_tokenizer_core_tb;
  import ctt_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_CYCLES     = 150;

  typedef struct packed {
    res_t r;
    logic last;
  } token_exp_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte   = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic       out_item_kind;
  logic [2:0] out_token_kind;
  logic [7:0] out_lexeme_byte;
  logic       out_last_result;

  mode_t      lex_state     = MODE_ROOT;
  logic       comment_to_value = 1'b0;
  logic       name_dotted   = 1'b0;
  res_t       step_res[$];
  token_exp_t pending_tokens[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int bytes_sent     = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;

  config_text_tokenizer_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_token_kind  (out_token_kind),
    .out_lexeme_byte (out_lexeme_byte),
    .out_last_result (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic root_byte(input logic [7:0] b);
    if (is_letter(b)) begin
      lex_state   = MODE_NAME;
      name_dotted = 1'b0;
      step_res.push_back(res_t'{KIND_LEXEME, TK_NAME, b});
    end else if (b == CH_HASH) begin
      comment_to_value = 1'b0;
      lex_state        = MODE_COMMENT;
    end else if (b == CH_EQUAL) begin
      step_res.push_back(res_t'{KIND_COMPLETE, TK_EQUAL, 8'h00});
      lex_state = MODE_AFTER_EQ;
    end else if (b == CH_LBRACK) begin
      step_res.push_back(res_t'{KIND_COMPLETE, TK_OPEN, 8'h00});
    end else if (b == CH_RBRACK) begin
      step_res.push_back(res_t'{KIND_COMPLETE, TK_CLOSE, 8'h00});
    end
  endtask

  task automatic predict_tokens(input logic [7:0] b, input logic eot);
    logic [2:0] nk;
    step_res.delete();
    nk = name_dotted ? TK_DOTTED : TK_NAME;
    if (eot) begin
      if (lex_state == MODE_NAME || lex_state == MODE_QUOTE) begin
        step_res.push_back(res_t'{KIND_COMPLETE, nk, 8'h00});
      end else if (lex_state == MODE_VALUE) begin
        step_res.push_back(res_t'{KIND_COMPLETE, TK_VALUE, 8'h00});
      end
      lex_state        = MODE_ROOT;
      comment_to_value = 1'b0;
      name_dotted      = 1'b0;
    end else begin
      case (lex_state)
        MODE_NAME: begin
          if (is_letter(b) || is_numeral(b)) begin
            step_res.push_back(res_t'{KIND_LEXEME, nk, b});
          end else if (b == CH_DOT) begin
            name_dotted = 1'b1;
            step_res.push_back(res_t'{KIND_LEXEME, TK_DOTTED, b});
          end else if (b == CH_QUOTE) begin
            lex_state = MODE_QUOTE;
            step_res.push_back(res_t'{KIND_LEXEME, nk, b});
          end else begin
            step_res.push_back(res_t'{KIND_COMPLETE, nk, 8'h00});
            lex_state   = MODE_ROOT;
            name_dotted = 1'b0;
            root_byte(b);
          end
        end
        MODE_QUOTE: begin
          step_res.push_back(res_t'{KIND_LEXEME, nk, b});
          if (b == CH_QUOTE) lex_state = MODE_NAME;
        end
        MODE_AFTER_EQ: begin
          if (b == CH_HASH) begin
            comment_to_value = 1'b1;
            lex_state        = MODE_COMMENT;
          end else if (b == CH_SPACE || b == CH_LF) begin
            lex_state = MODE_SKIP;
          end else begin
            lex_state = MODE_VALUE;
            step_res.push_back(res_t'{KIND_LEXEME, TK_VALUE, b});
          end
        end
        MODE_SKIP: begin
          if (b != CH_SPACE && b != CH_LF) begin
            lex_state = MODE_VALUE;
            step_res.push_back(res_t'{KIND_LEXEME, TK_VALUE, b});
          end
        end
        MODE_VALUE: begin
          if (b == CH_LF || b == CH_CR) begin
            step_res.push_back(res_t'{KIND_COMPLETE, TK_VALUE, 8'h00});
            lex_state = MODE_ROOT;
          end else begin
            step_res.push_back(res_t'{KIND_LEXEME, TK_VALUE, b});
          end
        end
        MODE_COMMENT: begin
          if (b == CH_LF) lex_state = comment_to_value ? MODE_SKIP : MODE_ROOT;
        end
        default: begin
          lex_state = MODE_ROOT;
          root_byte(b);
        end
      endcase
    end
    foreach (step_res[i]) begin
      pending_tokens.push_back(token_exp_t'{step_res[i], i == step_res.size() - 1});
    end
  endtask

  // ----------------------------------------------------------- monitors/checks

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_tokens(in_text_byte, in_end_of_text);
  end

  always @(posedge clk) begin
    token_exp_t want;
    token_exp_t got;
    if (rst_n && out_valid && out_ready) begin
      got = token_exp_t'{res_t'{out_item_kind, out_token_kind, out_lexeme_byte},
                         out_last_result};
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: kind=%0d tok=%0d byte=%02h last=%0d",
                   $realtime, out_item_kind, out_token_kind, out_lexeme_byte,
                   out_last_result);
      end else begin
        want = pending_tokens.pop_front();
        if (got.r.item_kind !== want.r.item_kind || got.r.token_kind !== want.r.token_kind ||
            got.r.lexeme_byte !== want.r.lexeme_byte || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: expected kind=%0d tok=%0d byte=%02h last=%0d,",
                     $realtime, want.r.item_kind, want.r.token_kind, want.r.lexeme_byte,
                     want.last,
                     " got kind=%0d tok=%0d byte=%02h last=%0d",
                     got.r.item_kind, got.r.token_kind, got.r.lexeme_byte, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------ stimulus

  // called and returns at a falling edge; valid stays high unless idling
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_key_name();
    int parts;
    int qlen;
    logic [7:0] b;
    send_byte($urandom_range(1) ? 8'(8'h61 + $urandom_range(25))
                                : 8'(8'h41 + $urandom_range(25)), 1'b0);
    parts = $urandom_range(6);
    repeat (parts) begin
      case ($urandom_range(3))
        0: send_byte($urandom_range(1) ? 8'(8'h61 + $urandom_range(25))
                                       : 8'(8'h41 + $urandom_range(25)), 1'b0);
        1: send_byte(8'(8'h30 + $urandom_range(9)), 1'b0);
        2: send_byte(CH_DOT, 1'b0);
        default: begin
          send_byte(CH_QUOTE, 1'b0);
          qlen = $urandom_range(4);
          repeat (qlen) begin
            do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
            send_byte(b, 1'b0);
          end
          send_byte(CH_QUOTE, 1'b0);
        end
      endcase
    end
  endtask

  task automatic gen_text_line();
    int sel;
    int n;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 38) begin
      // key = value
      send_key_name();
      n = $urandom_range(2);
      repeat (n) send_byte(CH_SPACE, 1'b0);
      send_byte(CH_EQUAL, 1'b0);
      if ($urandom_range(9) == 0) begin
        send_byte(CH_HASH, 1'b0);
        n = $urandom_range(3);
        repeat (n) begin
          do b = 8'($urandom_range(255)); while (b == CH_LF);
          send_byte(b, 1'b0);
        end
        send_byte(CH_LF, 1'b0);
      end
      n = $urandom_range(2);
      repeat (n) send_byte($urandom_range(1) ? CH_SPACE : CH_LF, 1'b0);
      n = $urandom_range(1, 6);
      repeat (n) begin
        do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR);
        send_byte(b, 1'b0);
      end
      if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)), 1'b1);
      else send_byte($urandom_range(1) ? CH_CR : CH_LF, 1'b0);
    end else if (sel < 53) begin
      // table header
      send_byte(CH_LBRACK, 1'b0);
      send_key_name();
      send_byte(CH_RBRACK, 1'b0);
      send_byte(CH_LF, 1'b0);
    end else if (sel < 61) begin
      send_byte(CH_HASH, 1'b0);
      n = $urandom_range(4);
      repeat (n) begin
        do b = 8'($urandom_range(255)); while (b == CH_LF);
        send_byte(b, 1'b0);
      end
      send_byte(CH_LF, 1'b0);
    end else if (sel < 66) begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end else if (sel < 74) begin
      send_byte($urandom_range(1) ? CH_SPACE : CH_LF, 1'b0);
    end else begin
      // noise, including broken lines
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(24) == 0);
    end
  endtask

  // ---------------------------------------------------------------- test tasks

  task automatic test_directed();
    send_byte("k", 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_HASH, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_DOT, 1'b0);
    send_byte("9", 1'b0);
    send_byte(CH_EQUAL, 1'b0);
    send_byte(CH_HASH, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_HASH, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte("Z", 1'b0);
    send_byte(CH_LBRACK, 1'b0);
    send_byte(CH_RBRACK, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("x", 1'b0);
    send_byte(CH_HASH, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_EQUAL, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte("q", 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(CH_EQUAL, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(CH_HASH, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = HOLD_CYCLES;
    send_byte("a", 1'b0);
    repeat (40) send_byte(8'(8'h61 + $urandom_range(25)), 1'b0);
    send_byte(CH_LF, 1'b0);
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      target = bytes_sent + 190;
      while (bytes_sent < target) gen_text_line();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ctt_pkg.sv
rtl/ctt_front.sv
rtl/ctt_queue.sv
rtl/ctt_back.sv
rtl/config_text_tokenizer_core.sv
verif/config_text_tokenizer_core_tb.sv
